// ===== src/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the peer session filter.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("assertion failed: label");

`endif

// ===== src/psf_pkg.sv =====
// ------------------------------------------------------------------------
// psf_pkg
// Types, request codes and field widths of the peer session filter.
// ------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

    localparam int MacW  = 48;
    localparam int SessW = 32;
    localparam int SeqW  = 16;
    localparam int ReqW  = 2;

    // Input stream tdata: transport_mac, sender_mac, peer_role,
    // session_id, seq_number, zero padding to whole bytes
    localparam int InFieldsW = 2 * MacW + 1 + SessW + SeqW;
    localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
    localparam int OutDataW  = 8;

    // Bit positions in the input tdata
    localparam int TmacLo = 0;
    localparam int SmacLo = TmacLo + MacW;
    localparam int RoleLo = SmacLo + MacW;
    localparam int SessLo = RoleLo + 1;
    localparam int SeqLo  = SessLo + SessW;

    // Request codes
    localparam logic [ReqW-1:0] REQ_ACCEPT = 2'd0;
    localparam logic [ReqW-1:0] REQ_BIND   = 2'd1;
    localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd2;

    // Multicast/group bit: low bit of the first byte
    localparam int MacGroupBit = MacW - 8;

    typedef struct packed {
        logic [ReqW-1:0]  req_type;
        logic [MacW-1:0]  transport_mac;
        logic [MacW-1:0]  sender_mac;
        logic             peer_role;
        logic [SessW-1:0] session_id;
        logic [SeqW-1:0]  seq_number;
    } item_t;

    typedef struct packed {
        logic             bound_flag;
        logic [MacW-1:0]  bound_transport_mac;
        logic [MacW-1:0]  bound_device_mac;
        logic             bound_role;
        logic [SessW-1:0] bound_session;
        logic [SeqW-1:0]  last_seq;
    } peer_state_t;

    typedef struct packed {
        logic accepted;
        logic is_bound;
    } result_t;

endpackage

`default_nettype wire

// ===== src/peer_session_filter.sv =====
// Path: a request accepted on s_axis is held in the input register, then its
//   result is registered in the result register and offered on m_axis.
// Throughput: one request per cycle; the input and result registers form a
//   two-stage pipeline that advances whenever the result slot is free.
// Reset: synchronous, active low; clears both pipeline stages and returns
//   the binding to unbound with all stored identity fields zero.
// ------------------------------------------------------------------------
// peer_session_filter
// Receive filter that binds to one peer and then passes only its fresh
// packets.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module peer_session_filter (
    input  wire                           aclk,
    input  wire                           aresetn,
    // Request stream
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, low bit up: transport_mac[47:0], sender_mac[95:48],
    // peer_role[96], session_id[128:97], seq_number[144:129], zero pad
    input  wire [psf_pkg::InDataW-1:0]    s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire [psf_pkg::ReqW-1:0]       s_axis_tuser,
    // Result stream
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // tdata, low bit up: accepted[0], is_bound[1], zero pad
    output logic [psf_pkg::OutDataW-1:0]  m_axis_tdata
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    psf_pkg::item_t       in_item_reg;
    psf_pkg::item_t       in_item_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    psf_pkg::result_t     out_res_reg;
    psf_pkg::peer_state_t state_q;
    psf_pkg::peer_state_t state_next;
    psf_pkg::result_t     res;
    logic                 advance;
    logic                 process;
    logic                 s_fire;

    // Pipeline control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Unpack the incoming request
    always_comb begin
        in_item_next.req_type      = s_axis_tuser;
        in_item_next.transport_mac =
            s_axis_tdata[psf_pkg::TmacLo +: psf_pkg::MacW];
        in_item_next.sender_mac    =
            s_axis_tdata[psf_pkg::SmacLo +: psf_pkg::MacW];
        in_item_next.peer_role     = s_axis_tdata[psf_pkg::RoleLo];
        in_item_next.session_id    =
            s_axis_tdata[psf_pkg::SessLo +: psf_pkg::SessW];
        in_item_next.seq_number    =
            s_axis_tdata[psf_pkg::SeqLo +: psf_pkg::SeqW];
    end

    assign in_valid_next  = s_fire ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign out_valid_next = process ? 1'b1
                            : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
        if (process) begin
            out_res_reg <= res;
        end
    end

    psf_check u_check (
        .item (in_item_reg),
        .cur  (state_q),
        .nxt  (state_next),
        .res  (res)
    );

    psf_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (process),
        .state_next (state_next),
        .state_q    (state_q)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(psf_pkg::OutDataW - 2){1'b0}},
                            out_res_reg.is_bound, out_res_reg.accepted};

    // A passed request always leaves the filter bound
    `ASSERT_IMPL(a_accept_bound, aclk, aresetn,
        out_valid_reg && out_res_reg.accepted, out_res_reg.is_bound)

    // A processed clear drops the binding
    `ASSERT_NEXT(a_clear_unbinds, aclk, aresetn,
        process && (in_item_reg.req_type == psf_pkg::REQ_CLEAR),
        !state_q.bound_flag && !out_res_reg.accepted)

    // Binding is only ever set by a processed bind request
    `ASSERT_IMPL(a_bind_source, aclk, aresetn,
        $rose(state_q.bound_flag),
        $past(process && (in_item_reg.req_type == psf_pkg::REQ_BIND)))

    // Result shows the binding state the request left behind
    `ASSERT_NEXT(a_result_tracks_state, aclk, aresetn,
        process, out_res_reg.is_bound == state_q.bound_flag)

endmodule

`default_nettype wire

// ===== src/psf_check.sv =====
// ------------------------------------------------------------------------
// psf_check
// Decision logic: evaluates one request against the current binding and
// produces the result and the next binding state.
// ------------------------------------------------------------------------
`default_nettype none

module psf_check (
    input  wire psf_pkg::item_t       item,
    input  wire psf_pkg::peer_state_t cur,
    output psf_pkg::peer_state_t      nxt,
    output psf_pkg::result_t          res
);

    logic [psf_pkg::SeqW-1:0] seq_dist;
    logic                     seq_newer;
    logic                     id_match;
    logic                     pass_ok;
    logic                     bind_ok;
    logic                     ok;

    // Sequence freshness: nonzero, distance in 1..half range minus one
    assign seq_dist  = item.seq_number - cur.last_seq;
    assign seq_newer = (item.seq_number != '0) && (seq_dist != '0)
                       && !seq_dist[psf_pkg::SeqW-1];

    // Identity match against the stored peer
    assign id_match = (item.transport_mac == cur.bound_transport_mac)
                      && (item.sender_mac == cur.bound_device_mac)
                      && (item.peer_role == cur.bound_role)
                      && (item.session_id == cur.bound_session);

    assign pass_ok = cur.bound_flag && id_match && seq_newer;

    // New binding: both MACs unicast, session and sequence nonzero
    assign bind_ok = (item.transport_mac != '0)
                     && !item.transport_mac[psf_pkg::MacGroupBit]
                     && (item.sender_mac != '0)
                     && !item.sender_mac[psf_pkg::MacGroupBit]
                     && (item.session_id != '0)
                     && (item.seq_number != '0);

    // Next state per request
    always_comb begin
        nxt = cur;
        ok  = 1'b0;
        unique case (item.req_type)
            psf_pkg::REQ_ACCEPT: begin
                ok = pass_ok;
                if (pass_ok) begin
                    nxt.last_seq = item.seq_number;
                end
            end
            psf_pkg::REQ_BIND: begin
                if (cur.bound_flag) begin
                    ok = pass_ok;
                    if (pass_ok) begin
                        nxt.last_seq = item.seq_number;
                    end
                end else if (bind_ok) begin
                    ok                      = 1'b1;
                    nxt.bound_flag          = 1'b1;
                    nxt.bound_transport_mac = item.transport_mac;
                    nxt.bound_device_mac    = item.sender_mac;
                    nxt.bound_role          = item.peer_role;
                    nxt.bound_session       = item.session_id;
                    nxt.last_seq            = item.seq_number;
                end
            end
            psf_pkg::REQ_CLEAR: begin
                nxt = '0;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    assign res.accepted = ok;
    assign res.is_bound = nxt.bound_flag;

endmodule

`default_nettype wire

// ===== src/psf_state.sv =====
// ------------------------------------------------------------------------
// psf_state
// Binding state registers, loaded once per processed request.
// ------------------------------------------------------------------------
`default_nettype none

module psf_state (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       load,
    input  wire psf_pkg::peer_state_t state_next,
    output psf_pkg::peer_state_t      state_q
);

    psf_pkg::peer_state_t state_reg;

    // Cleared to the unbound state on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    assign state_q = state_reg;

endmodule

`default_nettype wire

// ===== tb/tb_peer_session_filter.sv =====
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb_peer_session_filter
// Self-checking bench for the peer session filter. Requests go in on the
// request stream with random gaps. Results are drained with random stalls.
// A scoreboard keeps its own copy of the binding and predicts the verdict
// of every accepted request. It compares each result in order.
// ------------------------------------------------------------------------

// Tracks the peer binding and holds the verdicts still to come out
class binding_checker;

    localparam int AccBit   = 0;
    localparam int BoundBit = 1;

    psf_pkg::peer_state_t binding;
    psf_pkg::result_t     verdict_q[$];
    int                   errors;
    int                   result_count;

    function new();
        binding      = '0;
        errors       = 0;
        result_count = 0;
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    function bit is_unicast(logic [psf_pkg::MacW-1:0] mac);
        return mac != '0 && !mac[psf_pkg::MacGroupBit];
    endfunction

    // Newer: nonzero, and a forward distance of 1..0x7FFF (mod 2^16)
    function bit is_newer(logic [psf_pkg::SeqW-1:0] cand, logic [psf_pkg::SeqW-1:0] prev);
        logic [psf_pkg::SeqW-1:0] seq_gap;
        seq_gap = cand - prev;
        return cand != '0 && seq_gap != '0 && !seq_gap[psf_pkg::SeqW-1];
    endfunction

    // Packet from the bound peer with a fresh sequence; advances last_seq
    function bit pass_packet(psf_pkg::item_t req);
        if (!binding.bound_flag ||
            req.transport_mac != binding.bound_transport_mac ||
            req.sender_mac != binding.bound_device_mac ||
            req.peer_role != binding.bound_role ||
            req.session_id != binding.bound_session ||
            !is_newer(req.seq_number, binding.last_seq))
            return 1'b0;
        binding.last_seq = req.seq_number;
        return 1'b1;
    endfunction

    // Apply one accepted request and queue the verdict it should produce
    function void note_request(psf_pkg::item_t req);
        psf_pkg::result_t verdict;
        verdict.accepted = 1'b0;
        case (req.req_type)
            psf_pkg::REQ_ACCEPT: begin
                verdict.accepted = pass_packet(req);
            end
            psf_pkg::REQ_BIND: begin
                if (binding.bound_flag) begin
                    verdict.accepted = pass_packet(req);
                end else if (is_unicast(req.transport_mac) && is_unicast(req.sender_mac) &&
                             req.session_id != '0 && req.seq_number != '0) begin
                    binding.bound_flag          = 1'b1;
                    binding.bound_transport_mac = req.transport_mac;
                    binding.bound_device_mac    = req.sender_mac;
                    binding.bound_role          = req.peer_role;
                    binding.bound_session       = req.session_id;
                    binding.last_seq            = req.seq_number;
                    verdict.accepted            = 1'b1;
                end
            end
            psf_pkg::REQ_CLEAR: begin
                binding = '0;
            end
            default: begin
                // unknown code: state untouched
            end
        endcase
        verdict.is_bound = binding.bound_flag;
        verdict_q.push_back(verdict);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_result(logic [psf_pkg::OutDataW-1:0] data);
        psf_pkg::result_t want;
        result_count++;
        if (verdict_q.size() == 0) begin
            report($sformatf("result %0d (%h) with no request pending", result_count, data));
            return;
        end
        want = verdict_q.pop_front();
        if (data[AccBit] !== want.accepted)
            report($sformatf("result %0d accepted=%b, want %b",
                             result_count, data[AccBit], want.accepted));
        if (data[BoundBit] !== want.is_bound)
            report($sformatf("result %0d is_bound=%b, want %b",
                             result_count, data[BoundBit], want.is_bound));
    endtask

endclass

module tb_peer_session_filter;

    localparam logic [psf_pkg::ReqW-1:0] REQ_UNKNOWN = 2'd3;
    localparam int IdleLimit   = 2000;
    localparam int RandomCount = 1200;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [psf_pkg::InDataW-1:0]   s_axis_tdata = '0;
    logic [psf_pkg::ReqW-1:0]      s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [psf_pkg::OutDataW-1:0]  m_axis_tdata;

    binding_checker sb = new();

    psf_pkg::item_t tx_item = '0;     // request currently on the bus
    psf_pkg::item_t cur_peer;         // identity the random stream talks as
    logic [15:0]    tx_seq;
    bit             tx_steady = 1'b0;
    bit             rx_steady = 1'b0;
    int             stall_left = 0;
    int             rx_cycles = 0;
    int             idle_cycles = 0;

    peer_session_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 aclk = ~aclk;

    // Mostly short gaps, a few long ones, none during steady stretches
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random backpressure
    always @(negedge aclk) begin
        rx_cycles++;
        if (rx_cycles % 200 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap(rx_steady);
        end
    end

    // Handshake monitor, scoreboard hookup and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(tx_item);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no handshake for %0d cycles", IdleLimit);
                $display("[peer_session_filter] ERROR");
                $finish;
            end
        end
    end

    // Called and returns at a falling edge
    task send_request(input psf_pkg::item_t req);
        int gap;
        logic [psf_pkg::InDataW-1:0] data;
        gap = pick_gap(tx_steady);
        data = '0;
        data[psf_pkg::TmacLo +: psf_pkg::MacW]  = req.transport_mac;
        data[psf_pkg::SmacLo +: psf_pkg::MacW]  = req.sender_mac;
        data[psf_pkg::RoleLo]                   = req.peer_role;
        data[psf_pkg::SessLo +: psf_pkg::SessW] = req.session_id;
        data[psf_pkg::SeqLo +: psf_pkg::SeqW]   = req.seq_number;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= req.req_type;
        tx_item       <= req;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold off the sender until every outstanding verdict has come back
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic psf_pkg::item_t retarget(psf_pkg::item_t base,
                                                logic [psf_pkg::ReqW-1:0] req,
                                                logic [15:0] seq);
        psf_pkg::item_t it;
        it = base;
        it.req_type = req;
        it.seq_number = seq;
        return it;
    endfunction

    function automatic logic [psf_pkg::MacW-1:0] random_unicast();
        logic [psf_pkg::MacW-1:0] mac;
        mac = 48'({$urandom(), $urandom()});
        mac[psf_pkg::MacGroupBit] = 1'b0;
        if (mac == '0)
            mac[0] = 1'b1;
        return mac;
    endfunction

    function automatic psf_pkg::item_t random_item();
        psf_pkg::item_t it;
        it.req_type      = 2'($urandom_range(0, 3));
        it.transport_mac = 48'({$urandom(), $urandom()});
        it.sender_mac    = 48'({$urandom(), $urandom()});
        it.peer_role     = 1'($urandom_range(0, 1));
        it.session_id    = $urandom();
        it.seq_number    = 16'($urandom());
        return it;
    endfunction

    function void fresh_peer();
        cur_peer               = '0;
        cur_peer.transport_mac = random_unicast();
        cur_peer.sender_mac    = random_unicast();
        cur_peer.peer_role     = 1'($urandom_range(0, 1));
        cur_peer.session_id    = $urandom();
        if (cur_peer.session_id == '0)
            cur_peer.session_id = 32'd1;
        tx_seq = 16'($urandom_range(1, 16'hFFFF));
    endfunction

    // Mostly in-order traffic from the current peer, plus rebinds,
    // corrupted and stale packets, clears and noise
    function psf_pkg::item_t next_random_item();
        psf_pkg::item_t it;
        int             r;
        it = retarget(cur_peer, psf_pkg::REQ_ACCEPT, tx_seq);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            it.req_type = psf_pkg::REQ_CLEAR;
        end else if (r < 5) begin
            it = random_item();
            it.req_type = REQ_UNKNOWN;
        end else if (r < 12) begin
            fresh_peer();
            it = retarget(cur_peer, psf_pkg::REQ_BIND, tx_seq);
        end else if (r < 17) begin
            tx_seq += 16'($urandom_range(1, 4));
            it = retarget(cur_peer, psf_pkg::REQ_BIND, tx_seq);
        end else if (r < 22) begin
            it = random_item();
        end else if (r < 32) begin
            case ($urandom_range(0, 6))
                0: it.transport_mac ^= 48'd1 << $urandom_range(0, psf_pkg::MacW - 1);
                1: it.sender_mac ^= 48'd1 << $urandom_range(0, psf_pkg::MacW - 1);
                2: it.peer_role = ~it.peer_role;
                3: it.session_id ^= 32'd1 << $urandom_range(0, psf_pkg::SessW - 1);
                4: it.seq_number = tx_seq - 16'($urandom_range(0, 16'h7FFF));
                5: it.seq_number = tx_seq + 16'h8000;
                default: it.seq_number = '0;
            endcase
        end else begin
            if ($urandom_range(0, 9) == 0)
                tx_seq += 16'($urandom_range(1, 16'h7FFF));
            else
                tx_seq += 16'($urandom_range(1, 4));
            it.seq_number = tx_seq;
        end
        return it;
    endfunction

    // Binding rules, sequence window edges and request codes
    task run_directed();
        psf_pkg::item_t peer_a;
        psf_pkg::item_t probe;
        peer_a = '0;
        peer_a.transport_mac = 48'hFEFF_FFFF_FFFF;
        peer_a.sender_mac    = 48'h0000_0000_0001;
        peer_a.peer_role     = 1'b1;
        peer_a.session_id    = 32'hFFFF_FFFF;

        // accept while unbound
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'hFFFF));
        // bind refused: zero or group MACs, zero session, zero sequence
        probe = retarget(peer_a, psf_pkg::REQ_BIND, 16'hFFFF);
        probe.transport_mac = '0;
        send_request(probe);
        probe = retarget(peer_a, psf_pkg::REQ_BIND, 16'hFFFF);
        probe.transport_mac[psf_pkg::MacGroupBit] = 1'b1;
        send_request(probe);
        probe = retarget(peer_a, psf_pkg::REQ_BIND, 16'hFFFF);
        probe.sender_mac = 48'h0100_0000_0000;
        send_request(probe);
        probe.sender_mac = '0;
        send_request(probe);
        probe = retarget(peer_a, psf_pkg::REQ_BIND, 16'hFFFF);
        probe.session_id = '0;
        send_request(probe);
        send_request(retarget(peer_a, psf_pkg::REQ_BIND, 16'h0000));
        send_request(retarget(peer_a, REQ_UNKNOWN, 16'h0001));

        // good bind, then sequence window edges across the wrap
        send_request(retarget(peer_a, psf_pkg::REQ_BIND, 16'hFFFF));
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'hFFFF));
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h0000));
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h0001));
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8001));
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8000));

        // identity mismatches
        probe = retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8001);
        probe.peer_role = 1'b0;
        send_request(probe);
        probe = retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8001);
        probe.session_id = 32'h7FFF_FFFF;
        send_request(probe);
        probe = retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8001);
        probe.transport_mac[0] = 1'b0;
        send_request(probe);
        probe = retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8001);
        probe.sender_mac[psf_pkg::MacW-1] = 1'b1;
        send_request(probe);

        // bind while bound acts as accept; other peer is refused
        send_request(retarget(peer_a, psf_pkg::REQ_BIND, 16'h8001));
        probe = retarget(peer_a, psf_pkg::REQ_BIND, 16'h8002);
        probe.transport_mac = 48'h0000_0000_0002;
        send_request(probe);
        send_request(retarget(peer_a, REQ_UNKNOWN, 16'h8002));

        // clear, then smallest legal binding
        send_request(retarget(peer_a, psf_pkg::REQ_CLEAR, 16'h8002));
        send_request(retarget(peer_a, psf_pkg::REQ_ACCEPT, 16'h8002));
        probe = '0;
        probe.transport_mac = 48'd1;
        probe.sender_mac    = 48'd1;
        probe.session_id    = 32'd1;
        send_request(retarget(probe, psf_pkg::REQ_BIND, 16'h0001));
        send_request(retarget(probe, psf_pkg::REQ_CLEAR, 16'h0001));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        drain();

        fresh_peer();
        for (int n = 0; n < RandomCount; n++) begin
            if (n % 150 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399)
                drain();
            send_request(next_random_item());
        end

        // Wait for the tail, then keep watching for anything stray
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0)
            $display("[peer_session_filter] OK");
        else
            $display("[peer_session_filter] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/psf_pkg.sv
src/psf_check.sv
src/psf_state.sv
src/peer_session_filter.sv
tb/tb_peer_session_filter.sv
